[rtl/core/bgr_pkg.sv]
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types and constants of the button gesture recogniser.
// ----------------------------------------------------------------------------
package bgr_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int GEST_W      = 2;
    localparam int TIME_W      = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG     = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] TAP_RST      = 16'd300;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd600;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    // Gesture codes
    localparam logic [GEST_W-1:0] GEST_SINGLE = 2'd0;
    localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd1;
    localparam logic [GEST_W-1:0] GEST_LONG   = 2'd2;

    // Gesture queue geometry
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [GEST_W-1:0] gesture;
        logic              last;
    } beat_t;

    // Up to two gesture beats produced by one tick
    typedef struct packed {
        logic [1:0] count;
        beat_t      b0;
        beat_t      b1;
    } push_t;

endpackage

[rtl/core/bgr_front.sv]
// ----------------------------------------------------------------------------
// bgr_front
// Tick processor: debounce, timers, gestures; one tick a cycle while accepted.
// ----------------------------------------------------------------------------
module bgr_front #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bgr_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                accept,
    input  logic                                button_level,
    output bgr_pkg::push_t                      push
);
    import bgr_pkg::*;

    localparam logic [32:0] MAX_DELAY = (33'd1 << DELAY_WIDTH) - 33'd1;

    logic [CFG_W-1:0]       debounce_reg, tap_limit_reg, window_reg, long_time_reg;

    logic [TIME_W-1:0]      tick_reg, tick_next;
    logic                   started_reg, started_next;
    logic                   raw_reg, raw_next;
    logic [DELAY_WIDTH-1:0] settle_cnt_reg, settle_cnt_next;
    logic                   settle_act_reg, settle_act_next;
    logic                   deb_reg, deb_next;
    logic                   armed_reg, armed_next;
    logic                   long_rep_reg, long_rep_next;
    logic                   tap_wait_reg, tap_wait_next;
    logic [TIME_W-1:0]      last_acc_reg, last_acc_next;
    logic [TIME_W-1:0]      press_reg, press_next;
    logic [TIME_W-1:0]      first_rel_reg, first_rel_next;
    logic [DELAY_WIDTH-1:0] long_cd_reg, long_cd_next;
    logic                   long_act_reg, long_act_next;
    logic [DELAY_WIDTH-1:0] tap_cd_reg, tap_cd_next;
    logic                   tap_act_reg, tap_act_next;
    push_t                  push_c;

    // Clamp a delay register to the counter width
    function automatic logic [DELAY_WIDTH-1:0] delay_load(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = {{(32-CFG_W){1'b0}}, v};
        if (v32 > MAX_DELAY[31:0])
            return MAX_DELAY[DELAY_WIDTH-1:0];
        return v32[DELAY_WIDTH-1:0];
    endfunction

    function automatic push_t emit(input push_t p, input logic [GEST_W-1:0] g);
        push_t r;
        r = p;
        if (p.count == 2'd0)
        begin
            r.b0.gesture = g;
            r.count      = 2'd1;
        end
        else if (p.count == 2'd1)
        begin
            r.b1.gesture = g;
            r.count      = 2'd2;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            tap_limit_reg <= TAP_RST;
            window_reg    <= WINDOW_RST;
            long_time_reg <= LONG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg  <= cfg_data;
                CFG_TAP:      tap_limit_reg <= cfg_data;
                CFG_WINDOW:   window_reg    <= cfg_data;
                CFG_LONG:     long_time_reg <= cfg_data;
                default:      debounce_reg  <= debounce_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [TIME_W-1:0]      now;
        logic [DELAY_WIDTH-1:0] cnt;
        logic [TIME_W-1:0]      since_acc, since_press, since_rel;

        now             = tick_reg;
        tick_next       = tick_reg + 32'd1;
        started_next    = started_reg;
        raw_next        = raw_reg;
        settle_cnt_next = settle_cnt_reg;
        settle_act_next = settle_act_reg;
        deb_next        = deb_reg;
        armed_next      = armed_reg;
        long_rep_next   = long_rep_reg;
        tap_wait_next   = tap_wait_reg;
        last_acc_next   = last_acc_reg;
        press_next      = press_reg;
        first_rel_next  = first_rel_reg;
        long_cd_next    = long_cd_reg;
        long_act_next   = long_act_reg;
        tap_cd_next     = tap_cd_reg;
        tap_act_next    = tap_act_reg;
        push_c          = '0;
        cnt             = '0;
        since_acc       = now - last_acc_reg;
        since_press     = now - press_reg;
        since_rel       = now - first_rel_reg;

        if (!started_reg)
        begin
            // First tick: sample only
            started_next  = 1'b1;
            raw_next      = button_level;
            deb_next      = button_level;
            armed_next    = !button_level;
            last_acc_next = now;
            press_next    = now;
        end
        else
        begin
            if (button_level != raw_reg)
            begin
                raw_next        = button_level;
                settle_cnt_next = delay_load(debounce_reg);
                settle_act_next = 1'b1;
            end

            // Long-press timer
            if (long_act_reg)
            begin
                cnt = long_cd_reg;
                if (cnt != '0)
                    cnt = cnt - DELAY_WIDTH'(1);
                long_cd_next = cnt;
                if (cnt == '0)
                begin
                    long_act_next = 1'b0;
                    if (armed_reg && deb_reg && !long_rep_reg)
                    begin
                        long_rep_next = 1'b1;
                        tap_wait_next = 1'b0;
                        tap_act_next  = 1'b0;
                        tap_cd_next   = '0;
                        push_c        = emit(push_c, GEST_LONG);
                    end
                end
            end

            // Double-click window timer
            if (tap_act_next)
            begin
                cnt = tap_cd_next;
                if (cnt != '0)
                    cnt = cnt - DELAY_WIDTH'(1);
                tap_cd_next = cnt;
                if (cnt == '0)
                begin
                    tap_act_next = 1'b0;
                    if (armed_reg && tap_wait_next)
                    begin
                        tap_wait_next = 1'b0;
                        push_c        = emit(push_c, GEST_SINGLE);
                    end
                end
            end

            // Settle timer and edge acceptance
            if (settle_act_next)
            begin
                if (settle_cnt_next == '0)
                begin
                    settle_act_next = 1'b0;
                    if (button_level != deb_reg &&
                        since_acc >= {{(TIME_W-CFG_W){1'b0}}, debounce_reg})
                    begin
                        last_acc_next = now;
                        if (button_level)
                        begin
                            deb_next = 1'b1;
                            if (armed_reg)
                            begin
                                press_next    = now;
                                long_rep_next = 1'b0;
                                long_cd_next  = delay_load(long_time_reg);
                                long_act_next = 1'b1;
                            end
                        end
                        else
                        begin
                            deb_next      = 1'b0;
                            long_act_next = 1'b0;
                            long_cd_next  = '0;
                            if (!armed_reg)
                            begin
                                armed_next    = 1'b1;
                                long_rep_next = 1'b0;
                                tap_wait_next = 1'b0;
                                tap_act_next  = 1'b0;
                                tap_cd_next   = '0;
                            end
                            else if (!long_rep_next)
                            begin
                                if (since_press > {{(TIME_W-CFG_W){1'b0}}, tap_limit_reg})
                                begin
                                    tap_wait_next = 1'b0;
                                    tap_act_next  = 1'b0;
                                    tap_cd_next   = '0;
                                    push_c        = emit(push_c, GEST_SINGLE);
                                end
                                else if (!tap_wait_next)
                                begin
                                    tap_wait_next  = 1'b1;
                                    first_rel_next = now;
                                    tap_cd_next    = delay_load(window_reg);
                                    tap_act_next   = 1'b1;
                                end
                                else if (since_rel <= {{(TIME_W-CFG_W){1'b0}}, window_reg})
                                begin
                                    tap_wait_next = 1'b0;
                                    tap_act_next  = 1'b0;
                                    tap_cd_next   = '0;
                                    push_c        = emit(push_c, GEST_DOUBLE);
                                end
                                else
                                begin
                                    push_c         = emit(push_c, GEST_SINGLE);
                                    tap_wait_next  = 1'b1;
                                    first_rel_next = now;
                                    tap_cd_next    = delay_load(window_reg);
                                    tap_act_next   = 1'b1;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    settle_cnt_next = settle_cnt_next - DELAY_WIDTH'(1);
                end
            end
        end

        // Mark the final beat of the tick
        if (push_c.count == 2'd1)
            push_c.b0.last = 1'b1;
        else if (push_c.count == 2'd2)
            push_c.b1.last = 1'b1;
    end

    always_comb
    begin
        push = push_c;
        if (!accept)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            started_reg    <= 1'b0;
            raw_reg        <= 1'b0;
            settle_cnt_reg <= '0;
            settle_act_reg <= 1'b0;
            deb_reg        <= 1'b0;
            armed_reg      <= 1'b1;
            long_rep_reg   <= 1'b0;
            tap_wait_reg   <= 1'b0;
            last_acc_reg   <= '0;
            press_reg      <= '0;
            first_rel_reg  <= '0;
            long_cd_reg    <= '0;
            long_act_reg   <= 1'b0;
            tap_cd_reg     <= '0;
            tap_act_reg    <= 1'b0;
        end
        else if (accept)
        begin
            tick_reg       <= tick_next;
            started_reg    <= started_next;
            raw_reg        <= raw_next;
            settle_cnt_reg <= settle_cnt_next;
            settle_act_reg <= settle_act_next;
            deb_reg        <= deb_next;
            armed_reg      <= armed_next;
            long_rep_reg   <= long_rep_next;
            tap_wait_reg   <= tap_wait_next;
            last_acc_reg   <= last_acc_next;
            press_reg      <= press_next;
            first_rel_reg  <= first_rel_next;
            long_cd_reg    <= long_cd_next;
            long_act_reg   <= long_act_next;
            tap_cd_reg     <= tap_cd_next;
            tap_act_reg    <= tap_act_next;
        end
    end

endmodule

[rtl/core/bgr_queue.sv]
// ----------------------------------------------------------------------------
// bgr_queue
// Gesture queue: in up to two beats a cycle, out one a cycle on out_ready.
// ----------------------------------------------------------------------------
module bgr_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bgr_pkg::push_t                  push,
    output logic                            space_ok,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bgr_pkg::GEST_W-1:0]      gesture,
    output logic                            last_of_tick
);
    import bgr_pkg::*;

    beat_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] head_reg, head_next;
    logic [QUEUE_PTR_W-1:0] tail_reg, tail_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;
    beat_t                  head_beat;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign space_ok  = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign head_beat = mem_reg[head_reg];
    assign gesture      = head_beat.gesture;
    assign last_of_tick = head_beat.last;

    assign head_next  = head_reg + QUEUE_PTR_W'(pop);
    assign tail_next  = tail_reg + QUEUE_PTR_W'(push.count);
    assign count_next = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail_reg] <= push.b0;
        if (push.count == 2'd2)
            mem_reg[tail_reg + QUEUE_PTR_W'(1)] <= push.b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/button_gesture_recognizer_core.sv]
// ----------------------------------------------------------------------------
// button_gesture_recognizer_core
// Debounced single-click, double-click and long-press recogniser.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the sampled button level.
// The block takes one tick per clock cycle while in_ready is high: the tick
// processor updates the debounce, long-press and double-click timers and
// writes the zero, one or two gesture beats the tick causes into a four-entry
// queue. A gesture beat is registered into the queue when its tick beat is
// accepted. The queue alone sets the input rate: in_ready drops while fewer
// than two entries are free, so ticks flow every cycle as long as the output
// side drains gestures. last_of_tick marks the final gesture of a tick.
// Configuration registers (debounce_time, tap_limit, double_window,
// long_time, indexes 0 to 3) are written with cfg_we and take effect on the
// next tick; write them only while the block is idle. Timer counts are
// DELAY_WIDTH bits wide and larger delays saturate. Tick timestamps wrap
// modulo 2^32. The first tick after reset only samples the level, and a
// press held from that point is ignored until its release.
// ----------------------------------------------------------------------------
module button_gesture_recognizer_core #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bgr_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                button_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bgr_pkg::GEST_W-1:0]          gesture,
    output logic                                last_of_tick
);
    import bgr_pkg::*;

    push_t push;
    logic  space_ok;
    logic  accept;

    // Accept a tick only when the queue can absorb the worst case of two beats
    assign in_ready = space_ok;
    assign accept   = in_valid && in_ready;

    bgr_front #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .button_level (button_level),
        .push         (push)
    );

    // Hold gestures here; a stalled consumer blocks ticks only once the queue fills
    bgr_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .space_ok     (space_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gesture      (gesture),
        .last_of_tick (last_of_tick)
    );

endmodule

[rtl/core/bgr_checker.sv]
// ----------------------------------------------------------------------------
// bgr_checker
// Port-level checks of the gesture recogniser, bound to the top level.
// ----------------------------------------------------------------------------
module bgr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [bgr_pkg::GEST_W-1:0]          gesture,
    input  logic                                last_of_tick
);
    import bgr_pkg::*;

    // Hold a stalled gesture beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture) && $stable(last_of_tick))
        else $error("gesture beat changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gesture == GEST_SINGLE || gesture == GEST_DOUBLE ||
                       gesture == GEST_LONG))
        else $error("undefined gesture code");

    // Double clicks and long presses always close their tick
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gesture == GEST_DOUBLE || gesture == GEST_LONG) |-> last_of_tick)
        else $error("double or long gesture not last of tick");

    // The second beat of a tick is queued together with the first
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_tick |=> out_valid)
        else $error("second beat of tick missing");

endmodule

bind button_gesture_recognizer_core bgr_checker u_bgr_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button gesture recogniser core.
// ----------------------------------------------------------------------------
// Drives one millisecond tick per input beat and runs a cycle-free model of
// the debounce, tap-window and long-press logic on every accepted tick. The
// gestures the model predicts are queued and compared with each output beat
// in order. The run goes through directed gestures (pressed at start, single,
// double and long press, hold past the tap limit, late second tap), a
// back-pressure phase that fills the gesture queue, randomised phases with
// fresh register settings (extremes included), and a final phase with no
// idling on either side.
// ----------------------------------------------------------------------------
module tb_top;
    import bgr_pkg::*;

    localparam int          DLY_W           = 16;
    localparam longint      DLY_MAX         = (64'd1 << DLY_W) - 1;
    localparam logic [CFG_W-1:0] CFG_MAX    = '1;
    localparam int unsigned ITEM_TARGET     = 1650;
    localparam int unsigned QUIET_ITEMS     = 150;
    localparam int unsigned PHASE_ITEMS     = 120;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_LIMIT     = 5000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RUN_LIMIT       = 5000000;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_DEBOUNCE;
    logic [CFG_W-1:0]       cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   button_level = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [GEST_W-1:0]      gesture;
    logic                   last_of_tick;

    // Bench control
    bit          jitter_on    = 1'b1;
    int unsigned hold_off_req = 0;
    int unsigned ticks_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned err_count    = 0;

    // Model copy of the registers, starting from their reset values
    logic [CFG_W-1:0] deb_ms    = DEBOUNCE_RST;
    logic [CFG_W-1:0] tap_ms    = TAP_RST;
    logic [CFG_W-1:0] window_ms = WINDOW_RST;
    logic [CFG_W-1:0] long_ms   = LONG_RST;

    // Model state
    logic [TIME_W-1:0] tick_now       = '0;
    logic [TIME_W-1:0] last_edge_time = '0;
    logic [TIME_W-1:0] press_time     = '0;
    logic [TIME_W-1:0] window_start   = '0;
    bit                seen_first     = 1'b0;
    bit                raw_level      = 1'b0;
    bit                settling       = 1'b0;
    bit                held           = 1'b0;
    bit                armed          = 1'b1;
    bit                long_done      = 1'b0;
    bit                tap_open       = 1'b0;
    bit                long_run       = 1'b0;
    bit                tap_run        = 1'b0;
    logic [DLY_W-1:0]  settle_cnt     = '0;
    logic [DLY_W-1:0]  long_cnt       = '0;
    logic [DLY_W-1:0]  tap_cnt        = '0;

    beat_t tick_beats[$];
    beat_t expected_gestures[$];

    button_gesture_recognizer_core #(
        .DELAY_WIDTH (DLY_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .button_level (button_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gesture      (gesture),
        .last_of_tick (last_of_tick)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Gesture model
    // ------------------------------------------------------------------------

    // Timer loads saturate at the counter width
    function automatic logic [DLY_W-1:0] sat_delay(input logic [CFG_W-1:0] v);
        return (v > DLY_MAX) ? DLY_W'(DLY_MAX) : DLY_W'(v);
    endfunction

    // One-shot countdown: advance and report expiry on this tick
    function automatic bit timer_done(inout bit running, inout logic [DLY_W-1:0] count);
        if (!running)
            return 1'b0;
        if (count != '0)
            count = count - DLY_W'(1);
        if (count == '0)
        begin
            running = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_gesture(input logic [GEST_W-1:0] g);
        beat_t b;
        if (tick_beats.size() < 2)
        begin
            b.gesture = g;
            b.last    = 1'b0;
            tick_beats.push_back(b);
        end
    endfunction

    function automatic void open_tap_window(input logic [TIME_W-1:0] now);
        tap_open     = 1'b1;
        window_start = now;
        tap_cnt      = sat_delay(window_ms);
        tap_run      = 1'b1;
    endfunction

    function automatic void close_tap_window();
        tap_open = 1'b0;
        tap_run  = 1'b0;
        tap_cnt  = '0;
    endfunction

    function automatic void take_release(input logic [TIME_W-1:0] now);
        held     = 1'b0;
        long_run = 1'b0;
        long_cnt = '0;
        // First release after a press held from start-up: arm and stay silent
        if (!armed)
        begin
            armed     = 1'b1;
            long_done = 1'b0;
            close_tap_window();
            return;
        end
        if (long_done)
            return;
        if ((now - press_time) > TIME_W'(tap_ms))
        begin
            close_tap_window();
            note_gesture(GEST_SINGLE);
            return;
        end
        if (!tap_open)
        begin
            open_tap_window(now);
            return;
        end
        if ((now - window_start) <= TIME_W'(window_ms))
        begin
            close_tap_window();
            note_gesture(GEST_DOUBLE);
        end
        else
        begin
            // Window already over but its expiry not yet seen
            note_gesture(GEST_SINGLE);
            open_tap_window(now);
        end
    endfunction

    // Work out the gestures one accepted tick causes and queue them
    function automatic void predict_tick(input logic level);
        logic [TIME_W-1:0] now;
        tick_beats.delete();
        now      = tick_now;
        tick_now = now + TIME_W'(1);

        if (!seen_first)
        begin
            seen_first     = 1'b1;
            raw_level      = level;
            held           = level;
            armed          = !level;
            last_edge_time = now;
            press_time     = now;
            return;
        end

        if (level != raw_level)
        begin
            raw_level  = level;
            settle_cnt = sat_delay(deb_ms);
            settling   = 1'b1;
        end

        // Order within a tick: long press, then tap window, then settle
        if (timer_done(long_run, long_cnt))
        begin
            if (armed && held && !long_done)
            begin
                long_done = 1'b1;
                close_tap_window();
                note_gesture(GEST_LONG);
            end
        end

        if (timer_done(tap_run, tap_cnt))
        begin
            if (armed && tap_open)
            begin
                tap_open = 1'b0;
                note_gesture(GEST_SINGLE);
            end
        end

        if (settling)
        begin
            if (settle_cnt == '0)
            begin
                settling = 1'b0;
                if (level != held && (now - last_edge_time) >= TIME_W'(deb_ms))
                begin
                    last_edge_time = now;
                    if (level)
                    begin
                        held = 1'b1;
                        if (armed)
                        begin
                            press_time = now;
                            long_done  = 1'b0;
                            long_cnt   = sat_delay(long_ms);
                            long_run   = 1'b1;
                        end
                    end
                    else
                    begin
                        take_release(now);
                    end
                end
            end
            else
            begin
                settle_cnt = settle_cnt - DLY_W'(1);
            end
        end

        if (tick_beats.size() != 0)
            tick_beats[tick_beats.size() - 1].last = 1'b1;
        foreach (tick_beats[i])
            expected_gestures.push_back(tick_beats[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    // Compare every accepted gesture beat with the oldest prediction
    always @(posedge clk)
    begin : check_gestures
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_gestures.size() == 0)
            begin
                note_mismatch($sformatf("gesture %0d last %0b with nothing expected",
                                        gesture, last_of_tick));
            end
            else
            begin
                want = expected_gestures.pop_front();
                if (gesture !== want.gesture || last_of_tick !== want.last)
                    note_mismatch($sformatf(
                        "beat %0d: expected gesture %0d last %0b, got gesture %0d last %0b",
                        results_seen, want.gesture, want.last, gesture, last_of_tick));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stretch;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req != 0)
            begin
                stretch      = hold_off_req;
                hold_off_req = 0;
                out_ready   <= 1'b0;
            end
            else if (jitter_on && $urandom_range(0, 3) == 0)
            begin
                stretch    = $urandom_range(1, 15);
                out_ready <= 1'b0;
            end
            else
            begin
                stretch    = $urandom_range(1, 20);
                out_ready <= 1'b1;
            end
            repeat (stretch) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender and shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one tick beat, hold it until accepted, then run the model on it
    task automatic send_tick(input logic level);
        int unsigned gap;
        gap = 0;
        if (jitter_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= level;
        do
            @(posedge clk);
        while (!in_ready);
        predict_tick(level);
        ticks_sent++;
    endtask

    task automatic hold_level(input logic level, input int unsigned count);
        repeat (count) send_tick(level);
    endtask

    // Drop valid and wait until every predicted gesture has been seen, then
    // let the pipeline settle for ticks that leave nothing behind
    task automatic wait_idle();
        int unsigned spent;
        in_valid <= 1'b0;
        spent = 0;
        do
        begin
            @(posedge clk);
            spent++;
        end
        while (expected_gestures.size() != 0 && spent < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles; call only when idle
    task automatic load_config(input logic [CFG_W-1:0] d, t, w, l);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [CFG_W-1:0]       val [4];
        idx = '{CFG_DEBOUNCE, CFG_TAP, CFG_WINDOW, CFG_LONG};
        val = '{d, t, w, l};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        deb_ms    = d;
        tap_ms    = t;
        window_ms = w;
        long_ms   = l;
    endtask

    function automatic int unsigned clip(input int unsigned v);
        return (v > 60) ? 60 : v;
    endfunction

    // A length scattered a few ticks either side of a threshold
    function automatic int unsigned near(input int unsigned mark);
        return ((mark > 2) ? mark - 2 : 0) + $urandom_range(0, 4);
    endfunction

    // One press and release with lengths drawn around the current thresholds,
    // now and then replaced by contact bounce
    task automatic random_gesture();
        int unsigned d;
        int unsigned press_len;
        int unsigned release_len;
        d = clip(deb_ms);
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: press_len = d + 1 + $urandom_range(0, clip(tap_ms));
            5, 6:          press_len = near(d + clip(tap_ms));
            default:       press_len = near(d + clip(long_ms)) + $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: release_len = d + 1 + $urandom_range(0, clip(window_ms));
            6, 7:             release_len = near(d + clip(window_ms));
            default:          release_len = d + clip(window_ms) + $urandom_range(2, 10);
        endcase
        hold_level(1'b1, press_len);
        hold_level(1'b0, release_len);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Button already down on the first tick: sampled only, nothing reported
    task automatic test_pressed_at_start();
        hold_level(1'b1, 3);
    endtask

    // Zero settle time so every edge is judged on its own tick
    task automatic test_directed_gestures();
        wait_idle();
        load_config('0, 16'd2, 16'd3, 16'd4);
        hold_level(1'b0, 1);                       // start-up press released: arm only
        hold_level(1'b1, 1); hold_level(1'b0, 1);  // tap opens the window
        hold_level(1'b1, 1); hold_level(1'b0, 1);  // second tap inside it: double
        hold_level(1'b1, 5); hold_level(1'b0, 1);  // long press, silent release
        hold_level(1'b1, 1); hold_level(1'b0, 4);  // lone tap, window expiry: single
        hold_level(1'b1, 3); hold_level(1'b0, 1);  // past the tap limit: single at once
    endtask

    // Shrink the window while one is open so the next tap lands after it
    task automatic test_late_second_tap();
        wait_idle();
        load_config('0, 16'd2, 16'd40, 16'd4);
        hold_level(1'b1, 1); hold_level(1'b0, 3);
        wait_idle();
        load_config('0, 16'd2, 16'd1, 16'd4);
        hold_level(1'b1, 1); hold_level(1'b0, 3);
    endtask

    // Stall the output for a long stretch while taps keep coming, so the
    // gesture queue fills and the input stalls; then pause the sender until
    // everything has drained
    task automatic test_backpressure();
        wait_idle();
        load_config(16'd1, 16'd4, 16'd2, 16'd12);
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (20)
        begin
            hold_level(1'b1, 3);
            hold_level(1'b0, 5);
        end
        wait_idle();
    endtask

    // Phases of random gestures, each under a fresh register setting
    task automatic test_random_phases();
        int unsigned phase_end;
        while (ticks_sent < ITEM_TARGET - QUIET_ITEMS)
        begin
            wait_idle();
            jitter_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       load_config('0, '0, '0, '0);
                1:       load_config('0, CFG_MAX, '0, CFG_MAX);
                2:       load_config(CFG_MAX, '0, CFG_MAX, '0);
                3:       load_config(16'd1, CFG_MAX, CFG_MAX, 16'd1);
                default: load_config(CFG_W'($urandom_range(0, 6)),
                                     CFG_W'($urandom_range(0, 25)),
                                     CFG_W'($urandom_range(0, 40)),
                                     CFG_W'($urandom_range(0, 60)));
            endcase
            phase_end = ticks_sent + PHASE_ITEMS;
            while (ticks_sent < phase_end)
                random_gesture();
        end
    endtask

    // Last stretch with both sides running flat out
    task automatic test_quiet_finish();
        wait_idle();
        jitter_on = 1'b0;
        load_config(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(2, 20)),
                    CFG_W'($urandom_range(2, 30)), CFG_W'($urandom_range(5, 50)));
        while (ticks_sent < ITEM_TARGET)
            random_gesture();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_pressed_at_start();
        test_directed_gestures();
        test_late_second_tap();
        test_backpressure();
        test_random_phases();
        test_quiet_finish();

        wait_idle();
        if (expected_gestures.size() != 0)
            note_mismatch($sformatf("%0d predicted gestures never arrived",
                                    expected_gestures.size()));

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial
    begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
